FILE: hw/rtl/h2r_pkg.sv
package h2r_pkg;

    // Component format: unsigned Q1.12, 4096 means 1.0
    localparam int COMP_FRAC_BITS = 12;
    localparam int COMP_W         = COMP_FRAC_BITS + 1;
    localparam int HUE_W          = 16;

    typedef logic [COMP_W-1:0] comp_t;
    typedef logic [HUE_W-1:0]  hue_t;

    localparam comp_t COMP_ONE = comp_t'(1) << COMP_FRAC_BITS;

    // Hue in 1/16 degree: 5760 per circle, 960 per sector.
    // Biasing the signed hue by 32768 shifts it by 3968 mod 5760;
    // adding 1792 more brings the offset to a whole multiple of 5760.
    localparam logic [16:0] HUE_BIAS    = 17'd1792;
    localparam logic [9:0]  SECTOR_SPAN = 10'd960;

    // floor(n / 15) = (n * RECIP15) >> RECIP_SHIFT for n below 2^16
    localparam logic [20:0] RECIP15     = 21'd1118482;
    localparam int          RECIP_SHIFT = 24;

    // floor(n / 6) = (n * 43) >> 8 for n below 128
    localparam logic [5:0]  RECIP6      = 6'd43;

    // Hexcone sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } sector_t;

endpackage

FILE: hw/rtl/h2r_in_if.sv
interface h2r_in_if;
    import h2r_pkg::*;

    logic  valid;
    logic  ready;
    hue_t  hue;
    comp_t saturation;
    comp_t brightness;
    comp_t opacity_in;

    modport source (output valid, output hue, output saturation, output brightness,
                    output opacity_in, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input opacity_in, output ready);
endinterface

FILE: hw/rtl/h2r_out_if.sv
interface h2r_out_if;
    import h2r_pkg::*;

    logic  valid;
    logic  ready;
    comp_t red;
    comp_t green;
    comp_t blue;
    comp_t opacity_out;

    modport source (output valid, output red, output green, output blue,
                    output opacity_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input opacity_out, output ready);
endinterface

FILE: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter. Takes one colour beat per clock (hue in signed 1/16
// degree, saturation, value and alpha in Q1.12) and returns red, green, blue
// and the untouched alpha in Q1.12. Throughput is one beat per cycle; every
// beat passes through the six-stage pipeline (hue reduction, sector and
// fraction split, then two rounds of 13-bit products and the sector routing).
// The whole pipeline halts while the output beat is held by the sink, so
// ready follows the sink combinationally. Saturation and value above 1.0 are
// clamped to 1.0; alpha is passed on bit for bit.
module hsv_to_rgb_converter (
    input  logic       clk,
    input  logic       rst_n,
    h2r_in_if.sink     hsv_in,
    h2r_out_if.source  rgb_out
);
    import h2r_pkg::*;

    localparam int STAGES = 6;

    logic              advance;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    // Stage A: clamp, bias hue, start divide by sector span
    logic [16:0] a_x_reg,   a_x_next;
    logic [31:0] a_quo_reg, a_quo_next;
    comp_t       a_sat_reg, a_sat_next;
    comp_t       a_val_reg, a_val_next;
    comp_t       a_opa_reg;

    // Stage B: sector index and remainder
    logic [9:0]  b_rem_reg,  b_rem_next;
    logic [6:0]  b_idx_reg,  b_idx_next;
    logic [3:0]  b_div6_reg, b_div6_next;
    comp_t       b_sat_reg, b_val_reg, b_opa_reg;

    // Stage C: sector, fraction product, p product
    sector_t     c_sector_reg, c_sector_next;
    logic [36:0] c_fprod_reg,  c_fprod_next;
    logic [25:0] c_pprod_reg,  c_pprod_next;
    comp_t       c_sat_reg, c_val_reg, c_opa_reg;

    // Stage D: s*f and s*(1-f)
    logic [11:0] c_frac;
    logic [24:0] d_sf_reg,  d_sf_next;
    logic [24:0] d_sfc_reg, d_sfc_next;
    comp_t       d_p_reg, d_val_reg, d_opa_reg;
    sector_t     d_sector_reg;

    // Stage E: v*(1-sf) and v*(1-s(1-f))
    logic [25:0] e_qprod_reg, e_qprod_next;
    logic [25:0] e_tprod_reg, e_tprod_next;
    comp_t       e_p_reg, e_val_reg, e_opa_reg;
    sector_t     e_sector_reg;

    // Stage F: routed output
    comp_t       f_red_reg,   f_red_next;
    comp_t       f_green_reg, f_green_next;
    comp_t       f_blue_reg,  f_blue_next;
    comp_t       f_opa_reg;

    // Flow control: whole pipe moves unless the output beat is held
    assign advance      = !vld_reg[STAGES-1] || rgb_out.ready;
    assign hsv_in.ready = advance;
    assign vld_next     = {vld_reg[STAGES-2:0], hsv_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage A logic
    always_comb
    begin
        a_sat_next = (hsv_in.saturation > COMP_ONE) ? COMP_ONE : hsv_in.saturation;
        a_val_next = (hsv_in.brightness > COMP_ONE) ? COMP_ONE : hsv_in.brightness;
        a_x_next   = {1'b0, ~hsv_in.hue[HUE_W-1], hsv_in.hue[HUE_W-2:0]} + HUE_BIAS;
        // x / 960 = (x >> 6) / 15
        a_quo_next = {21'd0, a_x_next[16:6]} * {11'd0, RECIP15};
    end

    // Stage B logic
    always_comb
    begin
        logic [16:0] span_mul;
        logic [11:0] idx_mul6;
        b_idx_next  = a_quo_reg[RECIP_SHIFT+6:RECIP_SHIFT];
        span_mul    = {10'd0, b_idx_next} * {7'd0, SECTOR_SPAN};
        b_rem_next  = 10'(a_x_reg - span_mul);
        idx_mul6    = {5'd0, b_idx_next} * {6'd0, RECIP6};
        b_div6_next = idx_mul6[11:8];
    end

    // Stage C logic
    always_comb
    begin
        logic [6:0]  six_mul;
        logic [15:0] rem_scaled;
        six_mul       = {1'b0, b_div6_reg, 2'b00} + {2'b00, b_div6_reg, 1'b0};
        c_sector_next = sector_t'(3'(b_idx_reg - six_mul));
        // f = rem * 4096 / 960 = (rem * 64) / 15
        rem_scaled    = {b_rem_reg, 6'd0};
        c_fprod_next  = {21'd0, rem_scaled} * {16'd0, RECIP15};
        c_pprod_next  = {13'd0, b_val_reg} * {13'd0, COMP_ONE - b_sat_reg};
    end

    // Stage D logic
    always_comb
    begin
        comp_t frac_c;
        c_frac     = c_fprod_reg[RECIP_SHIFT+11:RECIP_SHIFT];
        frac_c     = COMP_ONE - {1'b0, c_frac};
        d_sf_next  = {12'd0, c_sat_reg} * {12'd0, 1'b0, c_frac};
        d_sfc_next = {12'd0, c_sat_reg} * {12'd0, frac_c};
    end

    // Stage E logic
    always_comb
    begin
        comp_t q_fac;
        comp_t t_fac;
        q_fac        = COMP_ONE - d_sf_reg[24:COMP_FRAC_BITS];
        t_fac        = COMP_ONE - d_sfc_reg[24:COMP_FRAC_BITS];
        e_qprod_next = {13'd0, d_val_reg} * {13'd0, q_fac};
        e_tprod_next = {13'd0, d_val_reg} * {13'd0, t_fac};
    end

    // Stage F logic: hexcone routing
    always_comb
    begin
        comp_t q_val;
        comp_t t_val;
        // products never exceed 1.0 * 1.0, so bit 25 stays clear
        q_val = e_qprod_reg[24:COMP_FRAC_BITS];
        t_val = e_tprod_reg[24:COMP_FRAC_BITS];
        case (e_sector_reg)
            SEC_RED_YELLOW:
            begin
                f_red_next = e_val_reg; f_green_next = t_val;     f_blue_next = e_p_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                f_red_next = q_val;     f_green_next = e_val_reg; f_blue_next = e_p_reg;
            end
            SEC_GREEN_CYAN:
            begin
                f_red_next = e_p_reg;   f_green_next = e_val_reg; f_blue_next = t_val;
            end
            SEC_CYAN_BLUE:
            begin
                f_red_next = e_p_reg;   f_green_next = q_val;     f_blue_next = e_val_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                f_red_next = t_val;     f_green_next = e_p_reg;   f_blue_next = e_val_reg;
            end
            default:
            begin
                f_red_next = e_val_reg; f_green_next = e_p_reg;   f_blue_next = q_val;
            end
        endcase
    end

    // Payload registers, loaded on every pipeline step
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_x_reg      <= a_x_next;
            a_quo_reg    <= a_quo_next;
            a_sat_reg    <= a_sat_next;
            a_val_reg    <= a_val_next;
            a_opa_reg    <= hsv_in.opacity_in;

            b_rem_reg    <= b_rem_next;
            b_idx_reg    <= b_idx_next;
            b_div6_reg   <= b_div6_next;
            b_sat_reg    <= a_sat_reg;
            b_val_reg    <= a_val_reg;
            b_opa_reg    <= a_opa_reg;

            c_sector_reg <= c_sector_next;
            c_fprod_reg  <= c_fprod_next;
            c_pprod_reg  <= c_pprod_next;
            c_sat_reg    <= b_sat_reg;
            c_val_reg    <= b_val_reg;
            c_opa_reg    <= b_opa_reg;

            d_sf_reg     <= d_sf_next;
            d_sfc_reg    <= d_sfc_next;
            d_p_reg      <= c_pprod_reg[24:COMP_FRAC_BITS];
            d_val_reg    <= c_val_reg;
            d_opa_reg    <= c_opa_reg;
            d_sector_reg <= c_sector_reg;

            e_qprod_reg  <= e_qprod_next;
            e_tprod_reg  <= e_tprod_next;
            e_p_reg      <= d_p_reg;
            e_val_reg    <= d_val_reg;
            e_opa_reg    <= d_opa_reg;
            e_sector_reg <= d_sector_reg;

            f_red_reg    <= f_red_next;
            f_green_reg  <= f_green_next;
            f_blue_reg   <= f_blue_next;
            f_opa_reg    <= e_opa_reg;
        end
    end

    assign rgb_out.valid       = vld_reg[STAGES-1];
    assign rgb_out.red         = f_red_reg;
    assign rgb_out.green       = f_green_reg;
    assign rgb_out.blue        = f_blue_reg;
    assign rgb_out.opacity_out = f_opa_reg;

endmodule
